@@ src/jsu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg: shared types and constants for the JSON string unescaper
// Decoder modes, status codes, the result beat type and the character
// constants used by the escape and UTF-8 logic.
// ----------------------------------------------------------------------------
package jsu_pkg;

   typedef enum logic [1:0] {
      MODE_OPEN  = 2'd0,
      MODE_PLAIN = 2'd1,
      MODE_ESC   = 2'd2,
      MODE_HEX   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_FRAMING    = 2'd1,
      STATUS_BAD_ESCAPE = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       is_status;
      status_type status;
   } item_type;

   localparam int MAX_PUSH = 3;

   // A decoded input byte yields up to three result beats.
   typedef struct packed {
      logic [1:0]   count;
      item_type [MAX_PUSH-1:0] item;
   } push_type;

   localparam logic [7:0] CHAR_QUOTE     = 8'h22;
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
   localparam logic [7:0] CHAR_U         = 8'h75;

   localparam logic [7:0]  UTF8_CONT       = 8'h80;
   localparam logic [7:0]  UTF8_LEAD2      = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3      = 8'hE0;
   localparam logic [15:0] UTF8_ONE_LIMIT  = 16'h0080;
   localparam logic [15:0] UTF8_TWO_LIMIT  = 16'h0800;

   // Bit 4 flags a valid hex digit, bits 3:0 carry its value.
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      unique case (c)
         8'h62:   r = 8'h08;
         8'h66:   r = 8'h0C;
         8'h6E:   r = 8'h0A;
         8'h72:   r = 8'h0D;
         8'h74:   r = 8'h09;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

@@ src/jsu_decode.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode: escape decoder
// Holds the per-string parse state and turns one registered input byte into
// zero to three result beats combinationally.
// ----------------------------------------------------------------------------
module jsu_decode (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   input  logic [7:0]        in_byte,
   input  logic              in_final,
   output jsu_pkg::push_type push
);
   import jsu_pkg::*;

   mode_type    mode_ff, mode_in;
   logic [1:0]  hex_count_ff, hex_count_in;
   logic [15:0] code_acc_ff, code_acc_in;
   logic        open_bad_ff, open_bad_in;
   logic        escape_bad_ff, escape_bad_in;

   logic [4:0]  hex;
   logic [15:0] code;
   logic        halted;

   assign hex    = hex_digit(in_byte);
   assign code   = {code_acc_ff[11:0], hex[3:0]};
   assign halted = open_bad_ff | escape_bad_ff;

   // Next state.
   always_comb begin
      mode_in       = mode_ff;
      hex_count_in  = hex_count_ff;
      code_acc_in   = code_acc_ff;
      open_bad_in   = open_bad_ff;
      escape_bad_in = escape_bad_ff;
      if (in_valid) begin
         if (in_final) begin
            mode_in       = MODE_OPEN;
            hex_count_in  = 2'd0;
            code_acc_in   = 16'd0;
            open_bad_in   = 1'b0;
            escape_bad_in = 1'b0;
         end else if (mode_ff == MODE_OPEN) begin
            open_bad_in = (in_byte != CHAR_QUOTE);
            mode_in     = MODE_PLAIN;
         end else if (!halted) begin
            unique case (mode_ff)
               MODE_PLAIN: begin
                  if (in_byte == CHAR_BACKSLASH) mode_in = MODE_ESC;
               end
               MODE_ESC: begin
                  if (in_byte == CHAR_U) begin
                     mode_in      = MODE_HEX;
                     hex_count_in = 2'd0;
                     code_acc_in  = 16'd0;
                  end else begin
                     mode_in = MODE_PLAIN;
                  end
               end
               MODE_HEX: begin
                  if (!hex[4]) begin
                     escape_bad_in = 1'b1;
                     mode_in       = MODE_PLAIN;
                     hex_count_in  = 2'd0;
                     code_acc_in   = 16'd0;
                  end else if (hex_count_ff == 2'd3) begin
                     mode_in      = MODE_PLAIN;
                     hex_count_in = 2'd0;
                     code_acc_in  = 16'd0;
                  end else begin
                     hex_count_in = hex_count_ff + 2'd1;
                     code_acc_in  = code;
                  end
               end
               MODE_OPEN: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   // Result beats.
   always_comb begin
      push = '0;
      if (in_valid) begin
         if (in_final) begin
            push.count             = 2'd1;
            push.item[0].is_status = 1'b1;
            // A framing fault outranks a bad escape.
            if (mode_ff == MODE_OPEN || open_bad_ff || in_byte != CHAR_QUOTE) begin
               push.item[0].status = STATUS_FRAMING;
            end else if (escape_bad_ff || mode_ff == MODE_HEX) begin
               push.item[0].status = STATUS_BAD_ESCAPE;
            end else begin
               push.item[0].status = STATUS_OK;
            end
         end else if (mode_ff != MODE_OPEN && !halted) begin
            unique case (mode_ff)
               MODE_PLAIN: begin
                  if (in_byte != CHAR_BACKSLASH) begin
                     push.count            = 2'd1;
                     push.item[0].out_byte = in_byte;
                  end
               end
               MODE_ESC: begin
                  if (in_byte != CHAR_U) begin
                     push.count            = 2'd1;
                     push.item[0].out_byte = map_escape(in_byte);
                  end
               end
               MODE_HEX: begin
                  if (hex[4] && hex_count_ff == 2'd3) begin
                     if (code < UTF8_ONE_LIMIT) begin
                        push.count            = 2'd1;
                        push.item[0].out_byte = code[7:0];
                     end else if (code < UTF8_TWO_LIMIT) begin
                        push.count            = 2'd2;
                        push.item[0].out_byte = UTF8_LEAD2 | {3'd0, code[10:6]};
                        push.item[1].out_byte = UTF8_CONT | {2'd0, code[5:0]};
                     end else begin
                        push.count            = 2'd3;
                        push.item[0].out_byte = UTF8_LEAD3 | {4'd0, code[15:12]};
                        push.item[1].out_byte = UTF8_CONT | {2'd0, code[11:6]};
                        push.item[2].out_byte = UTF8_CONT | {2'd0, code[5:0]};
                     end
                  end
               end
               MODE_OPEN: begin
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_OPEN;
         hex_count_ff  <= 2'd0;
         code_acc_ff   <= 16'd0;
         open_bad_ff   <= 1'b0;
         escape_bad_ff <= 1'b0;
      end else begin
         mode_ff       <= mode_in;
         hex_count_ff  <= hex_count_in;
         code_acc_ff   <= code_acc_in;
         open_bad_ff   <= open_bad_in;
         escape_bad_ff <= escape_bad_in;
      end
   end

endmodule

@@ src/jsu_out_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_queue: result queue
// Small register queue that takes up to three beats per cycle from the
// decoder and hands out one beat per cycle on the result channel on pop.
// ----------------------------------------------------------------------------
module jsu_out_queue #(
   parameter int DEPTH = 8
) (
   input  logic                         clock,
   input  logic                         reset,
   input  jsu_pkg::push_type            push,
   input  logic                         pop,
   output logic                         out_valid,
   output jsu_pkg::item_type            out_item,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   import jsu_pkg::*;

   localparam int PW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW:0] DEPTH_W = (PW + 1)'(DEPTH);

   item_type    slots_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [PW:0]   wr_sum [MAX_PUSH+1];
   logic [PW-1:0] wr_idx [MAX_PUSH+1];
   logic [PW:0]   rd_sum;

   always_comb begin
      for (int i = 0; i <= MAX_PUSH; i++) begin
         wr_sum[i] = {1'b0, wr_ptr_ff} + (PW + 1)'(i);
         if (wr_sum[i] >= DEPTH_W) wr_sum[i] = wr_sum[i] - DEPTH_W;
         wr_idx[i] = wr_sum[i][PW-1:0];
      end
   end

   assign rd_sum    = {1'b0, rd_ptr_ff} + (PW + 1)'(1);
   assign rd_ptr_in = pop ? ((rd_sum >= DEPTH_W) ? PW'(rd_sum - DEPTH_W) : rd_sum[PW-1:0])
                          : rd_ptr_ff;
   assign wr_ptr_in = wr_idx[push.count];
   assign count_in  = count_ff + CW'(push.count) - CW'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_PUSH; i++) begin
         if (2'(i) < push.count) slots_ff[wr_idx[i]] <= push.item[i];
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

endmodule

@@ src/json_string_unescaper.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescaper: JSON string unescaper, top level
// Input byte register, escape decoder and result queue.
// ----------------------------------------------------------------------------
// The block takes one input byte per cycle while req_ready is high, and
// each byte is captured in the input register, decoded combinationally in
// the next cycle and written as zero to three beats into the result queue,
// whose registered slots then offer the first result beat. A \u
// escape expands to up to three UTF-8 beats while the result port drains at
// most one beat per cycle, so sustained throughput is one input byte per
// cycle for plain text and is set by the result port otherwise. req_ready
// falls while the queue cannot take three more beats for every byte in
// flight; with the default FIFO_DEPTH of 8, even a result port drained at
// one beat per cycle holds off a byte that follows soon after a three-beat
// escape, and a slower drain stalls the input for longer. Each string ends
// with exactly one status beat.
module json_string_unescaper #(
   parameter int FIFO_DEPTH = 8
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_is_status,
   output logic [1:0] rsp_status
);
   import jsu_pkg::*;

   localparam int CW = $clog2(FIFO_DEPTH + 1);
   localparam logic [CW+1:0] READY_LIMIT = (CW + 2)'(FIFO_DEPTH - MAX_PUSH);

   logic          stage_valid_ff, stage_valid_in;
   logic [7:0]    stage_byte_ff;
   logic          stage_final_ff;
   push_type      push;
   item_type      head;
   logic [CW-1:0] fifo_count;
   logic [CW+1:0] committed;
   logic          req_fire;

   // Room is reserved for the byte in the input register and the new one.
   assign committed = (CW + 2)'(fifo_count) + (stage_valid_ff ? (CW + 2)'(MAX_PUSH) : '0);
   assign req_ready = (committed <= READY_LIMIT);
   assign req_fire  = req_valid & req_ready;
   assign stage_valid_in = req_fire;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_byte_ff  <= req_data_byte;
         stage_final_ff <= req_final_byte;
      end
   end

   jsu_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .in_valid (stage_valid_ff),
      .in_byte  (stage_byte_ff),
      .in_final (stage_final_ff),
      .push     (push)
   );

   jsu_out_queue #(
      .DEPTH (FIFO_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_valid & rsp_ready),
      .out_valid (rsp_valid),
      .out_item  (head),
      .count     (fifo_count)
   );

   assign rsp_out_byte  = head.out_byte;
   assign rsp_is_status = head.is_status;
   assign rsp_status    = head.status;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      (CW + 1)'(fifo_count) <= (CW + 1)'(FIFO_DEPTH))
      else $error("result queue holds more beats than its depth");

   a_room_for_decode: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff |-> ((CW + 2)'(fifo_count) <= READY_LIMIT))
      else $error("decoder may write into a queue without room for three beats");

   a_status_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_status) |-> (rsp_out_byte == 8'd0))
      else $error("status beat carries a non-zero byte");

   a_data_status_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_is_status) |-> (rsp_status == STATUS_OK))
      else $error("data beat carries a non-zero status");

endmodule
